// ----- design/pff_pkg.sv -----
// Shared package for the printf field formatter.
// Holds field widths, kind codes, character codes, the control/status structs
// and the character helper functions. No dependencies.
package pff_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_FIELD_DEF  = 64;

    // port field widths
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int FW_W    = 7;
    localparam int PREC_W  = 6;
    localparam int SIGN_W  = 2;
    localparam int CHAR_W  = 8;

    // conversion kinds
    localparam logic [KIND_W-1:0] KIND_SDEC   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UDEC   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HEX_LO = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEX_UP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PTR_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_PTR_UP = 3'd6;

    // sign modes for non-negative signed decimal
    localparam logic [SIGN_W-1:0] SIGN_NONE  = 2'd0;
    localparam logic [SIGN_W-1:0] SIGN_SPACE = 2'd1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_X_LO   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UP   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_A_UP   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
    localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

    localparam int NIL_LEN = 5;

    // controller -> datapath commands
    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
        logic size_step;
        logic emit_step;
    } pff_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic mode_none;
        logic need_conv;
        logic need_scan;
        logic conv_last;
        logic scan_hit;
        logic size_empty;
        logic out_free;
        logic emit_last;
    } pff_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [CHAR_W-1:0] ch;
        if (nib < 4'd10)
            ch = CH_ZERO + {4'h0, nib};
        else
            ch = (upper ? CH_A_UP : CH_A_LO) + {4'h0, nib} - 8'd10;
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] nil_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (idx)
            3'd0:    ch = CH_LPAREN;
            3'd1:    ch = CH_N;
            3'd2:    ch = CH_I;
            3'd3:    ch = CH_L;
            default: ch = CH_RPAREN;
        endcase
        return ch;
    endfunction

endpackage

// ----- design/pff_ctrl.sv -----
// Controller state machine of the printf field formatter.
// Sequences load, decimal conversion, digit scan, sizing and emission.
// Depends on pff_pkg.
module pff_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output pff_pkg::pff_cmd_t   cmd,
    input  pff_pkg::pff_stat_t  stat
);
    import pff_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_CONV = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_SIZE = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                priority if (stat.mode_none) state_next = ST_IDLE;
                else if (stat.need_conv)     state_next = ST_CONV;
                else if (stat.need_scan)     state_next = ST_SCAN;
                else                         state_next = ST_SIZE;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (stat.conv_last)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                    state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                cmd.size_step = 1'b1;
                state_next    = stat.size_empty ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_step = stat.out_free;
                if (stat.out_free && stat.emit_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // an accepted request always goes through the decode cycle
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_PREP)
        else $error("accepted request did not enter decode");

endmodule

// ----- design/pff_datapath.sv -----
// Datapath of the printf field formatter: request registers, shift-add
// BCD converter, digit scan, field sizing, segment counters, output register.
// Depends on pff_pkg.
module pff_datapath #(
    parameter int VALUE_BITS = pff_pkg::VALUE_BITS_DEF,
    parameter int MAX_FIELD  = pff_pkg::MAX_FIELD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pff_pkg::KIND_W-1:0]    kind,
    input  logic [pff_pkg::VALUE_W-1:0]   value,
    input  logic                          left_align,
    input  logic                          zero_pad,
    input  logic [pff_pkg::SIGN_W-1:0]    sign_mode,
    input  logic                          alt_prefix,
    input  logic [pff_pkg::FW_W-1:0]      field_width,
    input  logic                          has_precision,
    input  logic [pff_pkg::PREC_W-1:0]    precision,
    input  pff_pkg::pff_cmd_t             cmd,
    output pff_pkg::pff_stat_t            stat,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [pff_pkg::CHAR_W-1:0]    out_char,
    output logic                          last
);
    import pff_pkg::*;

    localparam int DIG_MAX  = (VALUE_BITS * 302) / 1000 + 1;
    localparam int BCD_W    = DIG_MAX * 4;
    localparam int IDX_BITS = $clog2(DIG_MAX);
    localparam int DIG_BITS = $clog2(DIG_MAX + 1);
    localparam int BIT_BITS = $clog2(VALUE_BITS + 1);
    localparam int CNT_BITS = $clog2(MAX_FIELD + DIG_MAX + 3);
    localparam logic [FW_W-1:0]   FW_CAP = FW_W'(MAX_FIELD);
    localparam logic [PREC_W-1:0] PR_CAP = PREC_W'(MAX_FIELD - 2);

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_DEC,
        MODE_HEX_LO,
        MODE_HEX_UP,
        MODE_CHAR,
        MODE_NIL
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic                  left_reg, left_next;
    logic                  zero_reg, zero_next;
    logic                  hp_reg, hp_next;
    logic                  want_reg, want_next;
    logic [CNT_BITS-1:0]   w_reg, w_next;
    logic [CNT_BITS-1:0]   pr_reg, pr_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BIT_BITS-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [IDX_BITS-1:0]   scan_idx_reg, scan_idx_next;
    logic [DIG_BITS-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [CNT_BITS-1:0]   sp_cnt_reg, sp_cnt_next;
    logic [1:0]            pfx_cnt_reg, pfx_cnt_next;
    logic [CHAR_W-1:0]     pfx_a_reg, pfx_a_next;
    logic [CHAR_W-1:0]     pfx_b_reg, pfx_b_next;
    logic [CNT_BITS-1:0]   zp_cnt_reg, zp_cnt_next;
    logic [CNT_BITS-1:0]   tot_cnt_reg, tot_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  last_reg, last_next;

    // request decode
    logic [VALUE_BITS-1:0] val_ext;
    logic                  val_nz;
    logic                  val_neg;
    logic [VALUE_BITS-1:0] ld_mag;
    mode_t                 ld_mode;
    logic [1:0]            ld_pfx_len;
    logic [CHAR_W-1:0]     ld_pfx_a;
    logic [CHAR_W-1:0]     ld_pfx_b;
    logic [FW_W-1:0]       fw_capped;
    logic [PREC_W-1:0]     pr_capped;

    assign val_ext   = VALUE_BITS'(value);
    assign val_nz    = |val_ext;
    assign val_neg   = (kind == KIND_SDEC) && val_ext[VALUE_BITS-1];
    assign ld_mag    = val_neg ? (~val_ext + 1'b1) : val_ext;
    assign fw_capped = (field_width > FW_CAP) ? FW_CAP : field_width;
    assign pr_capped = (precision > PR_CAP) ? PR_CAP : precision;

    always_comb
    begin
        ld_mode    = MODE_NONE;
        ld_pfx_len = 2'd0;
        ld_pfx_a   = CH_ZERO;
        ld_pfx_b   = CH_X_LO;
        unique case (kind)
            KIND_SDEC:
            begin
                ld_mode = MODE_DEC;
                if (val_neg)
                begin
                    ld_pfx_len = 2'd1;
                    ld_pfx_a   = CH_MINUS;
                end
                else if (sign_mode == SIGN_SPACE)
                begin
                    ld_pfx_len = 2'd1;
                    ld_pfx_a   = CH_SPACE;
                end
                else if (sign_mode != SIGN_NONE)
                begin
                    ld_pfx_len = 2'd1;
                    ld_pfx_a   = CH_PLUS;
                end
            end
            KIND_UDEC:
            begin
                ld_mode = MODE_DEC;
            end
            KIND_HEX_LO:
            begin
                ld_mode = MODE_HEX_LO;
                if (alt_prefix && val_nz)
                    ld_pfx_len = 2'd2;
            end
            KIND_HEX_UP:
            begin
                ld_mode  = MODE_HEX_UP;
                ld_pfx_b = CH_X_UP;
                if (alt_prefix && val_nz)
                    ld_pfx_len = 2'd2;
            end
            KIND_CHAR:
            begin
                ld_mode = MODE_CHAR;
            end
            KIND_PTR_LO:
            begin
                ld_mode    = val_nz ? MODE_HEX_LO : MODE_NIL;
                ld_pfx_len = val_nz ? 2'd2 : 2'd0;
            end
            KIND_PTR_UP:
            begin
                ld_mode    = val_nz ? MODE_HEX_UP : MODE_NIL;
                ld_pfx_len = val_nz ? 2'd2 : 2'd0;
                ld_pfx_b   = CH_X_UP;
            end
            default:
            begin
                ld_mode = MODE_NONE;
            end
        endcase
    end

    // shift-add-3 step of the binary to BCD conversion
    logic [BCD_W-1:0] bcd_adj;
    logic [BCD_W-1:0] bcd_dabble;

    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < DIG_MAX; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
        end
        bcd_dabble = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
    end

    // leading digit search, one digit per cycle from the top
    logic [3:0] scan_digit;
    logic       scan_hit;

    assign scan_digit = bcd_reg[scan_idx_reg*4 +: 4];
    assign scan_hit   = (scan_digit != 4'd0) || (scan_idx_reg == '0);

    // field sizing
    logic                numeric;
    logic [CNT_BITS-1:0] len_ext;
    logic [CNT_BITS-1:0] content;
    logic [CNT_BITS-1:0] size_zp;
    logic [CNT_BITS-1:0] body;
    logic [CNT_BITS-1:0] size_sp;
    logic [CNT_BITS-1:0] size_tot;

    assign numeric = (mode_reg != MODE_CHAR) && (mode_reg != MODE_NIL);
    assign len_ext = CNT_BITS'(dig_cnt_reg);
    assign content = len_ext + CNT_BITS'(pfx_cnt_reg);

    always_comb
    begin
        size_zp = '0;
        if (numeric)
        begin
            if (hp_reg)
                size_zp = (pr_reg > len_ext) ? (pr_reg - len_ext) : '0;
            else if (zero_reg)
                size_zp = (w_reg > content) ? (w_reg - content) : '0;
        end
        body     = content + size_zp;
        size_sp  = (w_reg > body) ? (w_reg - body) : '0;
        size_tot = body + size_sp;
    end

    // character selection for the current position
    logic [DIG_BITS-1:0] dig_m1;
    logic [DIG_BITS-1:0] nil_pos;
    logic [3:0]          emit_nib;
    logic [CHAR_W-1:0]   digit_out;
    logic [CHAR_W-1:0]   emit_ch;
    logic                emit_last;
    logic                out_free;

    assign dig_m1    = dig_cnt_reg - 1'b1;
    assign nil_pos   = DIG_BITS'(NIL_LEN) - dig_cnt_reg;
    assign emit_nib  = bcd_reg[dig_m1[IDX_BITS-1:0]*4 +: 4];
    assign emit_last = (tot_cnt_reg == CNT_BITS'(1));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (mode_reg)
            MODE_CHAR:   digit_out = char_reg;
            MODE_NIL:    digit_out = nil_char(nil_pos[2:0]);
            MODE_HEX_UP: digit_out = digit_char(emit_nib, 1'b1);
            default:     digit_out = digit_char(emit_nib, 1'b0);
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        left_next      = left_reg;
        zero_next      = zero_reg;
        hp_next        = hp_reg;
        want_next      = want_reg;
        w_next         = w_reg;
        pr_next        = pr_reg;
        char_next      = char_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        dig_cnt_next   = dig_cnt_reg;
        sp_cnt_next    = sp_cnt_reg;
        pfx_cnt_next   = pfx_cnt_reg;
        pfx_a_next     = pfx_a_reg;
        pfx_b_next     = pfx_b_reg;
        zp_cnt_next    = zp_cnt_reg;
        tot_cnt_next   = tot_cnt_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        emit_ch        = CH_SPACE;

        if (cmd.load)
        begin
            mode_next     = ld_mode;
            left_next     = left_align;
            zero_next     = zero_pad && !left_align;
            hp_next       = has_precision;
            want_next     = val_nz || !(has_precision && (precision == '0));
            w_next        = CNT_BITS'(fw_capped);
            pr_next       = CNT_BITS'(pr_capped);
            char_next     = value[CHAR_W-1:0];
            mag_next      = ld_mag;
            bcd_next      = (ld_mode == MODE_DEC) ? '0 : BCD_W'(val_ext);
            bit_cnt_next  = BIT_BITS'(VALUE_BITS);
            scan_idx_next = IDX_BITS'(DIG_MAX - 1);
            if (ld_mode == MODE_CHAR)
                dig_cnt_next = DIG_BITS'(1);
            else if (ld_mode == MODE_NIL)
                dig_cnt_next = DIG_BITS'(NIL_LEN);
            else
                dig_cnt_next = '0;
            pfx_cnt_next  = ld_pfx_len;
            pfx_a_next    = ld_pfx_a;
            pfx_b_next    = ld_pfx_b;
            sp_cnt_next   = '0;
            zp_cnt_next   = '0;
            tot_cnt_next  = '0;
        end

        if (cmd.conv_step)
        begin
            bcd_next     = bcd_dabble;
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end

        if (cmd.scan_step)
        begin
            if (scan_hit)
                dig_cnt_next = DIG_BITS'(scan_idx_reg) + 1'b1;
            else
                scan_idx_next = scan_idx_reg - 1'b1;
        end

        if (cmd.size_step)
        begin
            zp_cnt_next  = size_zp;
            sp_cnt_next  = size_sp;
            tot_cnt_next = size_tot;
        end

        if (cmd.emit_step)
        begin
            priority if (!left_reg && (sp_cnt_reg != '0))
            begin
                emit_ch     = CH_SPACE;
                sp_cnt_next = sp_cnt_reg - 1'b1;
            end
            else if (pfx_cnt_reg != 2'd0)
            begin
                emit_ch      = pfx_a_reg;
                pfx_a_next   = pfx_b_reg;
                pfx_cnt_next = pfx_cnt_reg - 1'b1;
            end
            else if (zp_cnt_reg != '0)
            begin
                emit_ch     = CH_ZERO;
                zp_cnt_next = zp_cnt_reg - 1'b1;
            end
            else if (dig_cnt_reg != '0)
            begin
                emit_ch      = digit_out;
                dig_cnt_next = dig_m1;
            end
            else
            begin
                emit_ch     = CH_SPACE;
                sp_cnt_next = sp_cnt_reg - 1'b1;
            end
            tot_cnt_next   = tot_cnt_reg - 1'b1;
            out_valid_next = 1'b1;
            out_char_next  = emit_ch;
            last_next      = emit_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NONE;
            bit_cnt_reg   <= '0;
            scan_idx_reg  <= '0;
            dig_cnt_reg   <= '0;
            sp_cnt_reg    <= '0;
            pfx_cnt_reg   <= 2'd0;
            zp_cnt_reg    <= '0;
            tot_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            bit_cnt_reg   <= bit_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            dig_cnt_reg   <= dig_cnt_next;
            sp_cnt_reg    <= sp_cnt_next;
            pfx_cnt_reg   <= pfx_cnt_next;
            zp_cnt_reg    <= zp_cnt_next;
            tot_cnt_reg   <= tot_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        zero_reg     <= zero_next;
        hp_reg       <= hp_next;
        want_reg     <= want_next;
        w_reg        <= w_next;
        pr_reg       <= pr_next;
        char_reg     <= char_next;
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        pfx_a_reg    <= pfx_a_next;
        pfx_b_reg    <= pfx_b_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        stat.mode_none  = (mode_reg == MODE_NONE);
        stat.need_conv  = (mode_reg == MODE_DEC) && want_reg;
        stat.need_scan  = ((mode_reg == MODE_DEC) || (mode_reg == MODE_HEX_LO) ||
                           (mode_reg == MODE_HEX_UP)) && want_reg;
        stat.conv_last  = (bit_cnt_reg == BIT_BITS'(1));
        stat.scan_hit   = scan_hit;
        stat.size_empty = (size_tot == '0);
        stat.out_free   = out_free;
        stat.emit_last  = emit_last;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    // total count matches the segment counters once sizing is done
    a_size_total: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.size_step |=> tot_cnt_reg == sp_cnt_reg + zp_cnt_reg +
                          CNT_BITS'(pfx_cnt_reg) + CNT_BITS'(dig_cnt_reg))
        else $error("field total disagrees with segment counts");

    // the final character leaves every segment drained
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step && emit_last |=> sp_cnt_reg == '0 && zp_cnt_reg == '0 &&
                                       pfx_cnt_reg == 2'd0 && dig_cnt_reg == '0)
        else $error("segments left over after last character");

    // the converter consumes every magnitude bit
    a_conv_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv_step && (bit_cnt_reg == BIT_BITS'(1)) |=> mag_reg == '0)
        else $error("magnitude bits left after conversion");

endmodule

// ----- design/printf_field_formatter_core.sv -----
// Top level of the printf field formatter: controller plus datapath.
// Depends on pff_pkg, pff_ctrl and pff_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one parsed integer-style
//   conversion request: kind, value, flags, field_width, precision.
//   Output channel (out_valid / out_stall) returns the field one character
//   per transfer in out_char, with last set on its final character. A field
//   that formats to nothing (kind seven, or zero width with no digits and no
//   sign) returns no transfers at all.
// Sequencing:
//   One request at a time. After acceptance: a decode step, then, if digits
//   are wanted, shift-add-3 BCD conversion of all VALUE_BITS bits for decimal
//   kinds and a leading-digit scan from the top digit down (decimal and hex),
//   then a sizing step, then the characters one by one. in_stall drops again
//   as soon as the last character is in the output register, so the next
//   request is taken while that character waits.
// Reset: rst_n is asynchronous; the block comes up idle, output empty.
// Stall: when out_stall is high with a character waiting, the output register
//   holds it and the character sequencer waits; nothing is dropped.
module printf_field_formatter_core #(
    parameter int VALUE_BITS = pff_pkg::VALUE_BITS_DEF,
    parameter int MAX_FIELD  = pff_pkg::MAX_FIELD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pff_pkg::KIND_W-1:0]    kind,
    input  logic [pff_pkg::VALUE_W-1:0]   value,
    input  logic                          left_align,
    input  logic                          zero_pad,
    input  logic [pff_pkg::SIGN_W-1:0]    sign_mode,
    input  logic                          alt_prefix,
    input  logic [pff_pkg::FW_W-1:0]      field_width,
    input  logic                          has_precision,
    input  logic [pff_pkg::PREC_W-1:0]    precision,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pff_pkg::CHAR_W-1:0]    out_char,
    output logic                          last
);
    import pff_pkg::*;

    // command and status between sequencer and datapath
    pff_cmd_t  cmd;
    pff_stat_t stat;

    pff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // value is taken VALUE_BITS wide; width capped to MAX_FIELD, precision to MAX_FIELD - 2
    pff_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .value         (value),
        .left_align    (left_align),
        .zero_pad      (zero_pad),
        .sign_mode     (sign_mode),
        .alt_prefix    (alt_prefix),
        .field_width   (field_width),
        .has_precision (has_precision),
        .precision     (precision),
        .cmd           (cmd),
        .stat          (stat),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_char      (out_char),
        .last          (last)
    );

endmodule

// ----- tb/printf_field_formatter_checker.sv -----
`timescale 1ns / 1ps
// Checker for the printf field formatter. It formats each accepted request itself
// and compares every returned character, in order, with the text it built.
// Depends on pff_pkg for port widths, kind codes and character codes.
module printf_field_formatter_checker #(
    parameter int MAX_FIELD = pff_pkg::MAX_FIELD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [pff_pkg::KIND_W-1:0]  kind,
    input  logic [pff_pkg::VALUE_W-1:0] value,
    input  logic                        left_align,
    input  logic                        zero_pad,
    input  logic [pff_pkg::SIGN_W-1:0]  sign_mode,
    input  logic                        alt_prefix,
    input  logic [pff_pkg::FW_W-1:0]    field_width,
    input  logic                        has_precision,
    input  logic [pff_pkg::PREC_W-1:0]  precision,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [pff_pkg::CHAR_W-1:0]  out_char,
    input  logic                        last,
    output int unsigned                 char_mismatches,
    output int unsigned                 chars_pending
);
    import pff_pkg::*;

    localparam int CHAR_CAP   = 64;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        int unsigned       req;
    } field_char_t;

    field_char_t field_chars[$];
    int unsigned req_count;

    // Builds the text of one field and queues it, last flag on its final char.
    function automatic void format_field(
        input logic [KIND_W-1:0]  k,
        input logic [VALUE_W-1:0] v,
        input logic               left,
        input logic               zpad,
        input logic [SIGN_W-1:0]  sm,
        input logic               alt,
        input logic [FW_W-1:0]    fw,
        input logic               hp,
        input logic [PREC_W-1:0]  pr,
        input int unsigned        req
    );
        int w, p, len, pfx_len, zeros, spaces;
        logic [CHAR_W-1:0] pfx[2];
        logic [CHAR_W-1:0] digits[$];
        logic [CHAR_W-1:0] text[$];
        logic [VALUE_W-1:0] mag, radix, d;
        logic upper, numeric, want_digits;
        field_char_t fc;

        w = (fw > MAX_FIELD) ? MAX_FIELD : int'(fw);
        p = (pr > MAX_FIELD - 2) ? MAX_FIELD - 2 : int'(pr);
        want_digits = (v != '0) || !(hp && p == 0);
        numeric = 1'b1;
        upper = 1'b0;
        radix = '0;
        mag = v;
        pfx_len = 0;

        case (k)
            KIND_SDEC: begin
                radix = 10;
                if (v[VALUE_W-1]) begin
                    mag = -v;       // most negative value keeps its full magnitude
                    pfx[0] = CH_MINUS;
                    pfx_len = 1;
                end else if (sm == SIGN_SPACE) begin
                    pfx[0] = CH_SPACE;
                    pfx_len = 1;
                end else if (sm != SIGN_NONE) begin
                    pfx[0] = CH_PLUS;
                    pfx_len = 1;
                end
            end
            KIND_UDEC: radix = 10;
            KIND_HEX_LO, KIND_HEX_UP: begin
                radix = 16;
                upper = (k == KIND_HEX_UP);
                if (alt && v != '0) begin
                    pfx[0] = CH_ZERO;
                    pfx[1] = upper ? CH_X_UP : CH_X_LO;
                    pfx_len = 2;
                end
            end
            KIND_CHAR: begin
                digits.push_back(v[CHAR_W-1:0]);
                numeric = 1'b0;
            end
            KIND_PTR_LO, KIND_PTR_UP: begin
                upper = (k == KIND_PTR_UP);
                if (v == '0) begin
                    digits = '{CH_LPAREN, CH_N, CH_I, CH_L, CH_RPAREN};
                    numeric = 1'b0;
                end else begin
                    radix = 16;
                    pfx[0] = CH_ZERO;
                    pfx[1] = upper ? CH_X_UP : CH_X_LO;
                    pfx_len = 2;
                end
            end
            default: return;    // unused kind code: empty field
        endcase

        if (radix != '0 && want_digits) begin
            do begin
                d = mag % radix;
                if (d < 10)
                    digits.push_front(CH_ZERO + d[CHAR_W-1:0]);
                else
                    digits.push_front((upper ? CH_A_UP : CH_A_LO) + d[CHAR_W-1:0] - 8'd10);
                mag = mag / radix;
            end while (mag != '0);
        end
        len = digits.size();

        zeros = 0;
        if (numeric) begin
            if (hp)
                zeros = p - len;
            else if (zpad && !left)
                zeros = w - len - pfx_len;
        end
        if (zeros < 0)
            zeros = 0;
        spaces = w - (len + pfx_len + zeros);
        if (spaces < 0)
            spaces = 0;

        if (!left)
            repeat (spaces) text.push_back(CH_SPACE);
        for (int i = 0; i < pfx_len; i++)
            text.push_back(pfx[i]);
        repeat (zeros) text.push_back(CH_ZERO);
        foreach (digits[i])
            text.push_back(digits[i]);
        if (left)
            repeat (spaces) text.push_back(CH_SPACE);

        while (text.size() > CHAR_CAP)
            void'(text.pop_back());
        foreach (text[i]) begin
            fc.ch = text[i];
            fc.last = (i == text.size() - 1);
            fc.req = req;
            field_chars.push_back(fc);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        field_char_t want;
        if (!rst_n) begin
            field_chars.delete();
            req_count = 0;
            char_mismatches = 0;
            chars_pending <= 0;
        end else begin
            // output side first: the previous field may finish on the same edge
            if (out_valid && !out_stall) begin
                if (field_chars.size() == 0) begin
                    char_mismatches++;
                    if (char_mismatches <= REPORT_MAX)
                        $display("%0t: unexpected char 0x%02h last %0b, nothing pending",
                                 $realtime, out_char, last);
                end else begin
                    want = field_chars.pop_front();
                    if (want.ch !== out_char || want.last !== last) begin
                        char_mismatches++;
                        if (char_mismatches <= REPORT_MAX)
                            $display("%0t: request %0d: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                                     $realtime, want.req, want.ch, want.last, out_char, last);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                format_field(kind, value, left_align, zero_pad, sign_mode, alt_prefix,
                             field_width, has_precision, precision, req_count);
                req_count++;
            end
            chars_pending <= field_chars.size();
        end
    end

endmodule

// ----- tb/printf_field_formatter_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for printf_field_formatter_core: directed and random requests
// with bursty timing and a patterned output stall; verdict from the checker.
// Depends on pff_pkg, printf_field_formatter_core and printf_field_formatter_checker.
module printf_field_formatter_core_tb;
    import pff_pkg::*;

    // sign modes the package leaves unnamed: plus, and the spare code
    // that the block must treat as plus
    localparam logic [SIGN_W-1:0] SIGN_PLUS      = 2'd2;
    localparam logic [SIGN_W-1:0] SIGN_PLUS_ALT  = 2'd3;
    // spare kind code: accepted, formats to nothing
    localparam logic [KIND_W-1:0] KIND_NONE      = 3'd7;

    localparam int RANDOM_REQUESTS = 140;
    // A decimal field waits out its BCD conversion before its first char;
    // sender gaps and receiver stall runs stay short, so going past
    // IDLE_LIMIT with no handshake on either side means the block is stuck.
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 200;

    localparam logic [VALUE_W-1:0] EXTREME_VALUES [4] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};

    typedef enum logic [1:0] {
        STALL_OFF,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               left;
        logic               zpad;
        logic [SIGN_W-1:0]  sm;
        logic               alt;
        logic [FW_W-1:0]    fw;
        logic               hp;
        logic [PREC_W-1:0]  pr;
    } fmt_request_t;

    // every block input starts at a known value
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic [KIND_W-1:0]   kind          = '0;
    logic [VALUE_W-1:0]  value         = '0;
    logic                left_align    = 1'b0;
    logic                zero_pad      = 1'b0;
    logic [SIGN_W-1:0]   sign_mode     = '0;
    logic                alt_prefix    = 1'b0;
    logic [FW_W-1:0]     field_width   = '0;
    logic                has_precision = 1'b0;
    logic [PREC_W-1:0]   precision     = '0;
    logic                out_stall     = 1'b0;

    logic                in_stall;
    logic                out_valid;
    logic [CHAR_W-1:0]   out_char;
    logic                last;

    int unsigned         char_mismatches;
    int unsigned         chars_pending;

    int                  burst_left  = 0;
    int                  idle_cycles = 0;
    int                  stall_left  = 0;
    stall_style_t        stall_style = STALL_OFF;

    always #2 clk = ~clk;

    printf_field_formatter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .value         (value),
        .left_align    (left_align),
        .zero_pad      (zero_pad),
        .sign_mode     (sign_mode),
        .alt_prefix    (alt_prefix),
        .field_width   (field_width),
        .has_precision (has_precision),
        .precision     (precision),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .last          (last)
    );

    printf_field_formatter_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .value           (value),
        .left_align      (left_align),
        .zero_pad        (zero_pad),
        .sign_mode       (sign_mode),
        .alt_prefix      (alt_prefix),
        .field_width     (field_width),
        .has_precision   (has_precision),
        .precision       (precision),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_char        (out_char),
        .last            (last),
        .char_mismatches (char_mismatches),
        .chars_pending   (chars_pending)
    );

    function automatic fmt_request_t make_req(
        input logic [KIND_W-1:0]  k,
        input logic [VALUE_W-1:0] v,
        input logic               left,
        input logic               zpad,
        input logic [SIGN_W-1:0]  sm,
        input logic               alt,
        input logic [FW_W-1:0]    fw,
        input logic               hp,
        input logic [PREC_W-1:0]  pr
    );
        fmt_request_t r;
        r.kind = k;
        r.value = v;
        r.left = left;
        r.zpad = zpad;
        r.sm = sm;
        r.alt = alt;
        r.fw = fw;
        r.hp = hp;
        r.pr = pr;
        return r;
    endfunction

    // Presents one request and returns on the edge that accepts it.
    // Requests go out in bursts; valid only drops at the start of a gap,
    // so inside a burst it stays high from one request to the next.
    task automatic send_request(input fmt_request_t r);
        int gap;
        if (burst_left == 0) begin
            // about a quarter of the bursts are long, back-to-back runs
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
                burst_left = $urandom_range(8, 24);
            end else begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 6);
            end
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        kind          <= r.kind;
        value         <= r.value;
        left_align    <= r.left;
        zero_pad      <= r.zpad;
        sign_mode     <= r.sm;
        alt_prefix    <= r.alt;
        field_width   <= r.fw;
        has_precision <= r.hp;
        precision     <= r.pr;
        in_valid      <= 1'b1;
        // payload stays put while the block stalls
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    // Receiver stall: picks a new random style whenever the stall_left countdown runs out, so that
    // stalls land on every phase of a field, with stall-free stretches too.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
            stall_left  <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            STALL_OFF:   out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_left % 5) < 2);
        endcase
    end

    // Watchdog: too long without a handshake on either channel ends the run.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (rst_n) begin
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        fmt_request_t r;
        int sent;
        int pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Argument order:
        //      kind         value          left zpad sign         alt  width hp prec
        // most negative value, full magnitude
        send_request(make_req(KIND_SDEC,   32'h8000_0000, 0, 0, SIGN_NONE,     0, 0,   0, 0));
        send_request(make_req(KIND_SDEC,   32'h7FFF_FFFF, 0, 0, SIGN_PLUS,     0, 0,   0, 0));
        send_request(make_req(KIND_SDEC,   32'h0000_0000, 0, 0, SIGN_SPACE,    0, 5,   0, 0));
        // spare sign code acts as plus, with zero padding after the sign
        send_request(make_req(KIND_SDEC,   32'd5,         0, 1, SIGN_PLUS_ALT, 0, 6,   0, 0));
        // left alignment overrides zero padding
        send_request(make_req(KIND_SDEC,   32'hFFFF_FFD6, 1, 1, SIGN_NONE,     0, 8,   0, 0));
        send_request(make_req(KIND_UDEC,   32'hFFFF_FFFF, 0, 0, SIGN_NONE,     0, 0,   1, 12));
        // zero value, precision zero, no width: empty field
        send_request(make_req(KIND_UDEC,   32'h0000_0000, 0, 0, SIGN_NONE,     0, 0,   1, 0));
        send_request(make_req(KIND_UDEC,   32'h0000_0000, 0, 0, SIGN_NONE,     0, 3,   1, 0));
        send_request(make_req(KIND_HEX_LO, 32'hDEAD_BEEF, 0, 1, SIGN_NONE,     1, 12,  0, 0));
        send_request(make_req(KIND_HEX_UP, 32'h0000_000A, 0, 0, SIGN_NONE,     1, 0,   1, 4));
        // zero hex value takes no prefix
        send_request(make_req(KIND_HEX_LO, 32'h0000_0000, 0, 0, SIGN_NONE,     1, 4,   0, 0));
        // character ignores zero padding, precision and sign
        send_request(make_req(KIND_CHAR,   32'h0000_0041, 0, 1, SIGN_PLUS,     0, 5,   1, 9));
        send_request(make_req(KIND_CHAR,   32'hFFFF_FF00, 1, 0, SIGN_NONE,     0, 3,   0, 0));
        // null pointer: "(nil)", flags other than width ignored
        send_request(make_req(KIND_PTR_LO, 32'h0000_0000, 0, 1, SIGN_PLUS,     0, 8,   1, 7));
        send_request(make_req(KIND_PTR_UP, 32'h0000_0010, 0, 1, SIGN_NONE,     0, 10,  0, 0));
        send_request(make_req(KIND_PTR_LO, 32'h0000_1234, 1, 0, SIGN_NONE,     0, 14,  1, 8));
        send_request(make_req(KIND_PTR_UP, 32'hFFFF_FFFF, 0, 0, SIGN_PLUS,     0, 0,   0, 0));
        send_request(make_req(KIND_NONE,   32'd123,       0, 0, SIGN_NONE,     0, 10,  0, 0));
        // width above the cap is clipped to the maximum field
        send_request(make_req(KIND_SDEC,   32'd1,         0, 0, SIGN_NONE,     0, 127, 0, 0));
        // precision above the cap; hex with prefix fills the whole field
        send_request(make_req(KIND_HEX_LO, 32'hFFFF_FFFF, 0, 0, SIGN_NONE,     1, 0,   1, 63));
        send_request(make_req(KIND_SDEC,   32'h8000_0000, 0, 0, SIGN_NONE,     0, 0,   1, 63));
        send_request(make_req(KIND_UDEC,   32'd10,        1, 0, SIGN_NONE,     0, 64,  0, 0));
        send_request(make_req(KIND_SDEC,   32'hFFFF_FFFF, 0, 0, SIGN_NONE,     0, 0,   0, 0));

        // Random part: mostly short fields, a few at or past the cap.
        // Requests with the spare kind code do not count toward the total.
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            r.kind = ($urandom_range(0, 19) == 0) ? KIND_NONE
                                                  : KIND_W'($urandom_range(0, 6));
            pick = $urandom_range(0, 7);
            case (pick)
                0:       r.value = '0;
                1:       r.value = $urandom_range(1, 20);
                2:       r.value = EXTREME_VALUES[$urandom_range(0, 3)];
                default: r.value = $urandom;
            endcase
            r.left = 1'($urandom_range(0, 1));
            r.zpad = 1'($urandom_range(0, 1));
            r.sm   = SIGN_W'($urandom_range(0, 3));
            r.alt  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                r.fw = FW_W'($urandom_range(0, 16));
            else if (pick < 9)
                r.fw = FW_W'($urandom_range(17, 64));
            else
                r.fw = FW_W'($urandom_range(65, 127));
            r.hp = 1'($urandom_range(0, 1));
            r.pr = ($urandom_range(0, 9) < 7) ? PREC_W'($urandom_range(0, 12))
                                              : PREC_W'($urandom_range(0, 63));
            send_request(r);
            if (r.kind != KIND_NONE)
                sent++;
        end
        in_valid <= 1'b0;

        // one edge so the pending count covers the last request
        @(posedge clk);
        while (chars_pending != 0)
            @(posedge clk);
        // catch any stray characters after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (char_mismatches == 0 && chars_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
